// ===== rtl/core/ucb_pkg.sv =====
`default_nettype none
package ucb_pkg;

	localparam int unsigned VISITS_W = 24;
	localparam int unsigned SCORE_W  = 32;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned RATIO_W  = 56;  // parent * 2^32 / visits
	localparam int unsigned ROOT_W   = 28;
	localparam int unsigned REM_W    = 29;
	localparam int unsigned ALU_W    = 31;
	localparam int unsigned CNT_W    = 6;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd5793;
	localparam logic [SCORE_W-1:0]  Q_MAX        = 32'h7FFF_FFFF;
	localparam logic [SCORE_W-1:0]  Q_MIN        = 32'h8000_0000;

	localparam logic [CNT_W-1:0] RATIO_STEPS_M1 = 6'd55;
	localparam logic [CNT_W-1:0] ROOT_STEPS_M1  = 6'd27;
	localparam logic [CNT_W-1:0] AVG_STEPS_M1   = 6'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATIO,
		ST_ROOT,
		ST_AVG,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ucb_child_select.sv =====
// UCB1 child selector. Present the children of one parent one per transfer on the
// s_ stream, the last one flagged with s_tlast; one result per list comes out on
// the m_ stream carrying the winner's position, its UCB value in Q16.16 and, on
// m_tuser, whether it won by having zero visits. For a visited child, one shared
// compare-subtract unit runs the 56-step restoring division for
// parent*2^32/visits, then 28 square-root digit steps, then the 32-step division
// for the average score, followed by a multiply step and then an add step.
// An unvisited child, or one arriving after the list already has an unvisited
// winner or beyond MAX_CHILDREN, skips the arithmetic and goes straight to the
// done state. s_tready is low while a child is worked on. The output register
// lets the next list start while a result still waits to be taken. Write
// exploration_weight (unsigned Q4.12) only while idle.
`default_nettype none
module ucb_child_select #(
	parameter int unsigned MAX_CHILDREN = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // child_visits[23:0], child_total_score[55:24],
	                                    // parent_visits[79:56]
	input  wire logic        s_tlast,   // last_child
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // best_index[7:0], best_value[39:8]
	output logic             m_tuser,   // chose_unvisited
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // exploration_weight
);

	localparam int unsigned PW = ($clog2(MAX_CHILDREN + 1) > 8) ?
		$clog2(MAX_CHILDREN + 1) : 8;
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_CHILDREN);

	ucb_pkg::state_t state_q, state_d;

	logic [ucb_pkg::WEIGHT_W-1:0] weight_q;
	logic [ucb_pkg::SCORE_W-1:0]  best_value_q;
	logic [ucb_pkg::INDEX_W-1:0]  best_index_q;
	logic [PW-1:0]                pos_q;
	logic                         unvisited_q;

	logic [ucb_pkg::VISITS_W-1:0] visits_q;
	logic [ucb_pkg::SCORE_W-1:0]  mag_q;
	logic                         neg_q;
	logic                         last_q;
	logic [ucb_pkg::INDEX_W-1:0]  cur_index_q;
	logic [ucb_pkg::RATIO_W-1:0]  sh_q;
	logic [ucb_pkg::REM_W-1:0]    rem_q;
	logic [ucb_pkg::ROOT_W-1:0]   root_q;
	logic [ucb_pkg::CNT_W-1:0]    cnt_q;
	logic [ucb_pkg::SCORE_W-1:0]  explo_q;

	logic                         out_valid_q;
	logic [39:0]                  out_data_q;
	logic                         out_user_q;

	logic [ucb_pkg::VISITS_W-1:0] in_visits;
	logic [ucb_pkg::SCORE_W-1:0]  in_total;
	logic [ucb_pkg::VISITS_W-1:0] in_parent;
	logic                         accept;
	logic                         active;
	logic                         out_free;

	// shared compare-subtract unit
	logic [ucb_pkg::ALU_W-1:0]    alu_a, alu_b;
	logic [ucb_pkg::ALU_W:0]      alu_diff;
	logic                         alu_ge;
	logic [ucb_pkg::REM_W-1:0]    alu_rem;

	logic [43:0]                  product;
	logic [33:0]                  avg_ext, sum;
	logic [ucb_pkg::SCORE_W-1:0]  value_sat;

	assign in_visits = s_tdata[23:0];
	assign in_total  = s_tdata[55:24];
	assign in_parent = s_tdata[79:56];
	assign accept    = s_tvalid && s_tready;
	assign active    = (pos_q < POS_MAX) && !unvisited_q;
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		if (state_q == ucb_pkg::ST_ROOT) begin
			alu_a = {rem_q[ucb_pkg::REM_W-1:0], sh_q[55:54]};
			alu_b = {1'b0, root_q, 2'b01};
		end else begin
			alu_a = {6'd0, rem_q[23:0], sh_q[55]};
			alu_b = {7'd0, visits_q};
		end
		alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
		alu_ge   = !alu_diff[ucb_pkg::ALU_W];
		alu_rem  = alu_ge ? alu_diff[ucb_pkg::REM_W-1:0] : alu_a[ucb_pkg::REM_W-1:0];
	end

	always_comb begin
		product = 44'(weight_q) * 44'(root_q);
		avg_ext = neg_q ? (34'd0 - {2'b00, sh_q[31:0]}) : {2'b00, sh_q[31:0]};
		sum     = avg_ext + {2'b00, explo_q};
		if (!sum[33] && (sum[32:31] != 2'b00)) begin
			value_sat = ucb_pkg::Q_MAX;
		end else if (sum[33] && (sum[32:31] != 2'b11)) begin
			value_sat = ucb_pkg::Q_MIN;
		end else begin
			value_sat = sum[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ucb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (active && (in_visits != '0)) ? ucb_pkg::ST_RATIO :
						ucb_pkg::ST_DONE;
				end
			end
			ucb_pkg::ST_RATIO: if (cnt_q == '0) state_d = ucb_pkg::ST_ROOT;
			ucb_pkg::ST_ROOT:  if (cnt_q == '0) state_d = ucb_pkg::ST_AVG;
			ucb_pkg::ST_AVG:   if (cnt_q == '0) state_d = ucb_pkg::ST_MUL;
			ucb_pkg::ST_MUL:   state_d = ucb_pkg::ST_ADD;
			ucb_pkg::ST_ADD:   state_d = ucb_pkg::ST_DONE;
			ucb_pkg::ST_DONE: begin
				if (!last_q || out_free) state_d = ucb_pkg::ST_IDLE;
			end
			default: state_d = ucb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = (state_q == ucb_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		m_tvalid  = out_valid_q;
		m_tdata   = out_data_q;
		m_tuser   = out_user_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ucb_pkg::ST_IDLE;
			weight_q     <= ucb_pkg::WEIGHT_RESET;
			best_value_q <= ucb_pkg::Q_MIN;
			best_index_q <= '0;
			pos_q        <= '0;
			unvisited_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) weight_q <= cfg_data;
			if ((state_q == ucb_pkg::ST_DONE) && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ucb_pkg::ST_IDLE: begin
					if (accept) begin
						if (pos_q < POS_MAX) pos_q <= pos_q + PW'(1);
						if (active && (in_visits == '0)) begin
							unvisited_q  <= 1'b1;
							best_index_q <= pos_q[7:0];
							best_value_q <= ucb_pkg::Q_MAX;
						end
					end
				end
				ucb_pkg::ST_ADD: begin
					if ($signed(value_sat) > $signed(best_value_q)) begin
						best_value_q <= value_sat;
						best_index_q <= cur_index_q;
					end
				end
				ucb_pkg::ST_DONE: begin
					if (last_q && out_free) begin
						best_value_q <= ucb_pkg::Q_MIN;
						best_index_q <= '0;
						pos_q        <= '0;
						unvisited_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ucb_pkg::ST_IDLE: begin
				if (accept) begin
					visits_q    <= in_visits;
					neg_q       <= in_total[31];
					mag_q       <= in_total[31] ? (32'd0 - in_total) : in_total;
					last_q      <= s_tlast;
					cur_index_q <= pos_q[7:0];
					sh_q        <= {in_parent, 32'd0};
					rem_q       <= '0;
					cnt_q       <= ucb_pkg::RATIO_STEPS_M1;
				end
			end
			ucb_pkg::ST_RATIO: begin
				// shift the dividend up, quotient bits in at the bottom
				sh_q  <= {sh_q[54:0], alu_ge};
				cnt_q <= cnt_q - ucb_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= ucb_pkg::ROOT_STEPS_M1;
				end else begin
					rem_q <= alu_rem;
				end
			end
			ucb_pkg::ST_ROOT: begin
				// one root digit per cycle, two radicand bits consumed
				sh_q   <= {sh_q[53:0], 2'b00};
				root_q <= {root_q[26:0], alu_ge};
				cnt_q  <= cnt_q - ucb_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					sh_q  <= {mag_q, 24'd0};
					rem_q <= '0;
					cnt_q <= ucb_pkg::AVG_STEPS_M1;
				end else begin
					rem_q <= alu_rem;
				end
			end
			ucb_pkg::ST_AVG: begin
				sh_q  <= {sh_q[54:0], alu_ge};
				rem_q <= alu_rem;
				cnt_q <= cnt_q - ucb_pkg::CNT_W'(1);
			end
			ucb_pkg::ST_MUL: begin
				explo_q <= product[43:12];
			end
			ucb_pkg::ST_DONE: begin
				if (last_q && out_free) begin
					out_data_q <= {best_value_q, best_index_q};
					out_user_q <= unvisited_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/ucb_checker.sv =====
`default_nettype none
module ucb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// an unvisited winner reports the top value
	a_unvisited_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[39:8] == 32'h7FFF_FFFF)
		else $error("unvisited winner without top value");

	// drop ready in the cycle after each transfer in
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after an input transfer");

endmodule

bind ucb_child_select ucb_checker u_ucb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
